// ----- sv/kalman_steer_command_framer_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the steering command framer
// Same-cycle-implication and next-cycle-implication checks, removed in synthesis.
// ----------------------------------------------------------------------------
`ifndef KALMAN_STEER_COMMAND_FRAMER_CORE_MACROS_SVH
`define KALMAN_STEER_COMMAND_FRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define KSCF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kscf: same-cycle check failed");

`define KSCF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kscf: next-cycle check failed");

`else

`define KSCF_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define KSCF_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- sv/kscf_pkg.sv -----
// ----------------------------------------------------------------------------
// kscf_pkg
// Shared types, constants and helpers of the steering command framer.
// ----------------------------------------------------------------------------
package kscf_pkg;

    localparam int SAMPLE_W = 24;
    localparam int EST_W    = 15;
    localparam int VAR_W    = 32;
    localparam int GAIN_W   = 16;
    localparam int QUOT_W   = 17;
    localparam int VAL_W    = 14;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [EST_W-1:0] ANGLE_LIMIT = 15'sd12464;

    localparam logic [7:0] FRAME_HEAD0   = 8'h5a;
    localparam logic [7:0] FRAME_HEAD1   = 8'ha5;
    localparam logic [7:0] FRAME_CHANNEL = 8'h02;
    localparam logic [7:0] FRAME_TAIL    = 8'haa;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_EST = 2'd0,
        REG_START_VAR = 2'd1,
        REG_MEAS_VAR  = 2'd2,
        REG_PROC_VAR  = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_REINIT = 1'b1
    } t_op;

    typedef struct packed {
        logic             start;
        logic [VAR_W-1:0] p;
        logic [VAR_W:0]   d;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic             load;
        logic [VAL_W-1:0] value;
    } t_frame_req;

    typedef struct packed {
        logic busy;
    } t_frame_stat;

    function automatic logic signed [EST_W-1:0] clamp_angle(
        input logic signed [SAMPLE_W-1:0] a
    );
        logic signed [SAMPLE_W-1:0] lim;
        lim = SAMPLE_W'(ANGLE_LIMIT);
        if (a > lim) begin
            return ANGLE_LIMIT;
        end else if (a < -lim) begin
            return -ANGLE_LIMIT;
        end
        return a[EST_W-1:0];
    endfunction

endpackage

// ----- sv/kalman_steer_command_framer_core.sv -----
// ----------------------------------------------------------------------------
// kalman_steer_command_framer_core
// Scalar Kalman smoothing of steering samples, framed as six-byte commands.
// ----------------------------------------------------------------------------
//  channel   direction  signals                         content
//  s_axis    in         tvalid tready tdata tuser       sample (tdata), op (tuser)
//  m_axis    out        tvalid tready tdata tlast       frame byte, last on tail
//  cfg       in         i_cfg_valid o_cfg_ready         index, 32-bit data
//
//  A sample occupies the filter through the update sequencer and the serial gain
//  divider; a reinit reloads the start values. The six frame bytes leave from
//  an output register one per cycle as long as the sink is ready, while the
//  filter already takes the next item; a busy framer holds the filter at send.
//  Reset is synchronous, active low; config is always ready.
// ----------------------------------------------------------------------------
module kalman_steer_command_framer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] steer_sample
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
    output logic        m_axis_tlast
);
    import kscf_pkg::*;

    t_frame_req  frame_req;
    t_frame_stat frame_stat;

    assign o_cfg_ready = 1'b1;

    kscf_filter u_filter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_op         (s_axis_tuser),
        .i_sample     (s_axis_tdata),
        .o_frame_req  (frame_req),
        .i_frame_stat (frame_stat)
    );

    kscf_framer u_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (frame_req),
        .o_stat   (frame_stat),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ----- sv/kscf_div.sv -----
// ----------------------------------------------------------------------------
// kscf_div
// Restoring radix-2 divider for the gain: floor(p * 2^16 / d), one bit a cycle.
// ----------------------------------------------------------------------------
module kscf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kscf_pkg::t_div_req i_req,
    output kscf_pkg::t_div_rsp o_rsp
);
    import kscf_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [VAR_W:0]    r_rem;
    logic [VAR_W:0]    r_d;
    logic [QUOT_W-1:0] r_dq;

    logic [VAR_W+1:0]  trial;
    logic              ge;
    logic [VAR_W:0]    n_rem;

    always_comb begin
        trial = {r_rem, r_dq[QUOT_W-1]};
        ge    = (trial >= {1'b0, r_d});
        if (ge) begin
            n_rem = (VAR_W+1)'(trial - {1'b0, r_d});
        end else begin
            n_rem = trial[VAR_W:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                // quotient fits 17 bits, so the top of the dividend is below d
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {2'b00, i_req.p[VAR_W-1:1]};
                r_dq   <= {i_req.p[0], 16'h0000};
                r_d    <= i_req.d;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dq  <= {r_dq[QUOT_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dq;

endmodule

// ----- sv/kscf_filter.sv -----
// ----------------------------------------------------------------------------
// kscf_filter
// Scalar Kalman update sequencer: config registers, state, shared multiplier.
// ----------------------------------------------------------------------------
`include "kalman_steer_command_framer_core_macros.svh"

module kscf_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kscf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_op,
    input  logic signed [kscf_pkg::SAMPLE_W-1:0] i_sample,
    output kscf_pkg::t_frame_req                o_frame_req,
    input  kscf_pkg::t_frame_stat               i_frame_stat
);
    import kscf_pkg::*;

    localparam logic [EST_W:0]       ANGLE_OFFSET  = 16'd12464;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_DIVGO, S_DIV, S_MSTEP, S_UEST, S_MVAR, S_UVAR, S_SEND
    } t_state;

    t_state r_state;

    logic signed [EST_W-1:0] r_start_est;
    logic [VAR_W-1:0]        r_start_var;
    logic [VAR_W-1:0]        r_meas_var;
    logic [VAR_W-1:0]        r_proc_var;

    logic signed [EST_W-1:0] r_est;
    logic [VAR_W-1:0]        r_var;
    logic signed [EST_W-1:0] r_obs;
    logic [VAR_W-1:0]        r_p;
    logic                    r_nz;
    logic [GAIN_W-1:0]       r_gain;
    logic signed [50:0]      r_prod;
    logic [VAL_W-1:0]        r_val;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic                     accept;
    logic [VAR_W:0]           p_sum;
    logic [VAR_W:0]           noise_sum;
    logic signed [EST_W:0]    diff;
    logic signed [32:0]       m_a;
    logic signed [17:0]       m_b;
    logic signed [50:0]       m_prod;
    logic signed [33:0]       rnd;
    logic signed [17:0]       est_sum;
    logic [EST_W:0]           est_ofs;
    logic [17:0]              scaled;

    kscf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        accept    = i_in_valid && o_in_ready;
        p_sum     = {1'b0, r_var} + {1'b0, r_proc_var};
        noise_sum = {1'b0, r_p} + {1'b0, r_meas_var};
        diff      = {r_obs[EST_W-1], r_obs} - {r_est[EST_W-1], r_est};

        // one multiplier, shared by the estimate step and the variance shrink
        if (r_state == S_MVAR) begin
            m_a = {1'b0, r_p};
            m_b = {1'b0, 17'(17'h10000 - {1'b0, r_gain})};
        end else begin
            m_a = {{17{diff[EST_W]}}, diff};
            m_b = {2'b00, r_gain};
        end
        m_prod = m_a * m_b;

        rnd     = r_prod[33:0] + 34'sd32768;
        est_sum = {{3{r_est[EST_W-1]}}, r_est} + rnd[33:16];
        est_ofs = {r_est[EST_W-1], r_est} + ANGLE_OFFSET;
        scaled  = {est_ofs[EST_W-1:0], 3'b000} + {2'b00, est_ofs[EST_W-1:0], 1'b0};

        div_req.start = (r_state == S_DIVGO);
        div_req.p     = r_p;
        div_req.d     = noise_sum;

        o_frame_req.load  = (r_state == S_SEND) && !i_frame_stat.busy;
        o_frame_req.value = r_val;
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start_est <= '0;
            r_start_var <= 32'd65536;
            r_meas_var  <= 32'd65536;
            r_proc_var  <= 32'd655;
            r_est       <= '0;
            r_var       <= 32'd65536;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_START_EST: r_start_est <= i_cfg_data[EST_W-1:0];
                    REG_START_VAR: r_start_var <= i_cfg_data;
                    REG_MEAS_VAR:  r_meas_var  <= i_cfg_data;
                    REG_PROC_VAR:  r_proc_var  <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_op == OP_REINIT) begin
                            r_est <= clamp_angle(SAMPLE_W'(r_start_est));
                            r_var <= r_start_var;
                        end else begin
                            r_obs   <= clamp_angle(i_sample);
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    // saturate P + Q
                    r_p     <= p_sum[VAR_W] ? '1 : p_sum[VAR_W-1:0];
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_nz    <= (noise_sum != '0);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        if (!r_nz) begin
                            r_gain <= '0;
                        end else if (div_rsp.quot[QUOT_W-1]) begin
                            r_gain <= '1;
                        end else begin
                            r_gain <= div_rsp.quot[GAIN_W-1:0];
                        end
                        r_state <= S_MSTEP;
                    end
                end
                S_MSTEP: begin
                    r_prod  <= m_prod;
                    r_state <= S_UEST;
                end
                S_UEST: begin
                    r_est   <= clamp_angle({{6{est_sum[17]}}, est_sum});
                    r_state <= S_MVAR;
                end
                S_MVAR: begin
                    r_prod  <= m_prod;
                    r_state <= S_UVAR;
                end
                S_UVAR: begin
                    r_var   <= r_prod[47:16];
                    r_val   <= scaled[17:4];
                    r_state <= S_SEND;
                end
                S_SEND: begin
                    if (!i_frame_stat.busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `KSCF_ASSERT_IMP(a_est_in_range, i_clk, i_rst_n, 1'b1, (r_est <= ANGLE_LIMIT && r_est >= -ANGLE_LIMIT))
    `KSCF_ASSERT_IMP(a_zero_sum_gain, i_clk, i_rst_n, (r_state == S_MSTEP && !r_nz), (r_gain == '0))
    `KSCF_ASSERT_NXT(a_busy_after_sample, i_clk, i_rst_n, (accept && !i_op), !o_in_ready)

endmodule

// ----- sv/kscf_framer.sv -----
// ----------------------------------------------------------------------------
// kscf_framer
// Serializes one command value into the six-byte frame through an output register.
// ----------------------------------------------------------------------------
`include "kalman_steer_command_framer_core_macros.svh"

module kscf_framer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kscf_pkg::t_frame_req  i_req,
    output kscf_pkg::t_frame_stat o_stat,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [7:0]            o_tdata,
    output logic                  o_tlast
);
    import kscf_pkg::*;

    localparam logic [2:0] LAST_BYTE = 3'd5;

    logic             r_busy;
    logic [2:0]       r_cnt;
    logic [VAL_W-1:0] r_val;
    logic             r_tvalid;
    logic [7:0]       r_tdata;
    logic             r_tlast;

    logic [15:0]      val16;
    logic [7:0]       cur_byte;

    always_comb begin
        val16 = {2'b00, r_val};
        case (r_cnt)
            3'd0:    cur_byte = FRAME_HEAD0;
            3'd1:    cur_byte = FRAME_HEAD1;
            3'd2:    cur_byte = FRAME_CHANNEL;
            3'd3:    cur_byte = val16[15:8];
            3'd4:    cur_byte = val16[7:0];
            default: cur_byte = FRAME_TAIL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_tvalid <= 1'b0;
            r_tlast  <= 1'b0;
        end else begin
            if (r_busy && (!r_tvalid || i_tready)) begin
                r_tvalid <= 1'b1;
                r_tdata  <= cur_byte;
                r_tlast  <= (r_cnt == LAST_BYTE);
                if (r_cnt == LAST_BYTE) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (r_tvalid && i_tready) begin
                r_tvalid <= 1'b0;
            end
            if (!r_busy && i_req.load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_val  <= i_req.value;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_tvalid    = r_tvalid;
    assign o_tdata     = r_tdata;
    assign o_tlast     = r_tlast;

    `KSCF_ASSERT_IMP(a_last_is_tail, i_clk, i_rst_n, (r_tvalid && r_tlast), (r_tdata == FRAME_TAIL))
    `KSCF_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, r_busy, (r_cnt <= LAST_BYTE))
    `KSCF_ASSERT_NXT(a_load_starts, i_clk, i_rst_n, (!r_busy && i_req.load), (r_busy && r_cnt == 3'd0))

endmodule
